// ===== hw/rtl/gdw_pkg.sv =====
package gdw_pkg;

  // Field widths of the input and result items.
  localparam int START_W = 4;
  localparam int DIV_W   = 5;
  localparam int TIME_W  = 32;
  localparam int STEP_W  = 31;
  localparam int DIR_W   = 2;
  localparam int INDEX_W = 12;

  // Packed stream widths, padded to whole bytes.
  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 48;

  // Direction codes; the unused code behaves as parallel.
  localparam logic [DIR_W-1:0] DIR_POS = 2'd0;
  localparam logic [DIR_W-1:0] DIR_NEG = 2'd1;
  localparam logic [DIR_W-1:0] DIR_PAR = 2'd2;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_DIV_X = 2'd0;
  localparam logic [1:0] REG_DIV_Y = 2'd1;
  localparam logic [1:0] REG_DIV_Z = 2'd2;

  // Saturation limits of signed Q16.16.
  localparam logic signed [TIME_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [TIME_W-1:0] Q_MIN = 32'sh8000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic advance;
  } gdw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
  } gdw_status_t;

endpackage

// ===== hw/rtl/gdw_ctrl.sv =====
module gdw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output gdw_pkg::gdw_cmd_t    cmd,
  input  gdw_pkg::gdw_status_t status
);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // A new ray is taken only between walks.
  assign in_tready   = (state_r == ST_IDLE);
  assign cmd.load    = in_tvalid && in_tready;
  // The walk moves one cell whenever the output register is free or is being emptied.
  assign cmd.advance = (state_r == ST_WALK) && (!out_valid_r || out_tready);
  assign out_tvalid  = out_valid_r;

  // Next state and output-valid flag.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.advance) begin
      out_valid_nxt = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (cmd.advance && status.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/gdw_datapath.sv =====
module gdw_datapath (
  input  logic                                       clk,
  input  gdw_pkg::gdw_cmd_t                          cmd,
  output gdw_pkg::gdw_status_t                       status,
  input  logic        [gdw_pkg::DIV_W-1:0]           div_eff [3],
  input  logic        [gdw_pkg::START_W-1:0]         start   [3],
  input  logic signed [gdw_pkg::TIME_W-1:0]          entry_t [3],
  input  logic        [gdw_pkg::STEP_W-1:0]          step_t  [3],
  input  logic        [gdw_pkg::DIR_W-1:0]           dir     [3],
  output logic        [gdw_pkg::INDEX_W-1:0]         out_cell_index,
  output logic signed [gdw_pkg::TIME_W-1:0]          out_exit_t,
  output logic                                       out_last
);

  localparam int DW  = gdw_pkg::DIV_W;
  localparam int TW  = gdw_pkg::TIME_W;
  localparam int SW  = gdw_pkg::STEP_W;
  localparam int PW  = DW + SW;
  localparam int LW  = PW + 2;

  // Walk state, one entry per axis.
  logic signed [TW-1:0] cross_r [3];
  logic        [SW-1:0] step_r  [3];
  logic        [DW-1:0] pos_r   [3];
  logic        [DW-1:0] dv_r    [3];
  logic                 neg_r   [3];
  logic        [2*DW-1:0] dxdy_r;

  // Load values computed from the accepted item.
  logic signed [TW-1:0] cross_ld [3];
  logic        [DW-1:0] pos_ld   [3];
  logic                 neg_ld   [3];

  // Walk step values.
  logic [1:0]           axis;
  logic signed [TW-1:0] exit_t;
  logic signed [TW-1:0] cross_sat;
  logic                 done;
  logic [15:0]          index_full;
  logic [DW-1:0]        pos_step;

  // First crossing per axis: one multiply, a wide add and a saturation.
  always_comb begin
    logic [DW-1:0]        s;
    logic [DW-1:0]        k;
    logic [PW-1:0]        prod;
    logic signed [LW-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      s = {1'b0, start[i]};
      if (s > div_eff[i] - 5'd1) begin
        s = div_eff[i] - 5'd1;
      end
      pos_ld[i] = s;
      neg_ld[i] = (dir[i] != gdw_pkg::DIR_POS);
      k = (dir[i] == gdw_pkg::DIR_POS) ? s + 5'd1 : div_eff[i] - s;
      prod = PW'(k) * PW'(step_t[i]);
      sum = $signed({{(LW-TW){entry_t[i][TW-1]}}, entry_t[i]}) + $signed({2'b00, prod});
      if (sum > $signed(LW'(gdw_pkg::Q_MAX))) begin
        cross_ld[i] = gdw_pkg::Q_MAX;
      end else if (sum < $signed({{(LW-TW){1'b1}}, gdw_pkg::Q_MIN})) begin
        cross_ld[i] = gdw_pkg::Q_MIN;
      end else begin
        cross_ld[i] = sum[TW-1:0];
      end
      if (dir[i] != gdw_pkg::DIR_POS && dir[i] != gdw_pkg::DIR_NEG) begin
        cross_ld[i] = gdw_pkg::Q_MAX;
      end
    end
  end

  // Pick the axis with the smallest crossing; ties go to the later axis, z over y over x.
  always_comb begin
    logic signed [TW:0] acc;
    if (cross_r[0] < cross_r[1] && cross_r[0] < cross_r[2]) begin
      axis = 2'd0;
    end else if (cross_r[1] < cross_r[2]) begin
      axis = 2'd1;
    end else begin
      axis = 2'd2;
    end
    exit_t = cross_r[axis];
    acc = {exit_t[TW-1], exit_t} + $signed({2'b00, step_r[axis]});
    case (acc[TW:TW-1])
      2'b01:   cross_sat = gdw_pkg::Q_MAX;
      2'b10:   cross_sat = gdw_pkg::Q_MIN;
      default: cross_sat = acc[TW-1:0];
    endcase
    if (neg_r[axis]) begin
      done     = (pos_r[axis] == '0);
      pos_step = pos_r[axis] - 5'd1;
    end else begin
      done     = (pos_r[axis] + 5'd1 == dv_r[axis]);
      pos_step = pos_r[axis] + 5'd1;
    end
    index_full = 16'(pos_r[0]) + 16'(dv_r[0]) * 16'(pos_r[1]) + 16'(dxdy_r) * 16'(pos_r[2]);
  end

  assign status.last = done;

  // Walk registers and the output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        cross_r[i] <= cross_ld[i];
        step_r[i]  <= step_t[i];
        pos_r[i]   <= pos_ld[i];
        dv_r[i]    <= div_eff[i];
        neg_r[i]   <= neg_ld[i];
      end
      dxdy_r <= div_eff[0] * div_eff[1];
    end else if (cmd.advance) begin
      cross_r[axis] <= cross_sat;
      if (!done) begin
        pos_r[axis] <= pos_step;
      end
    end
    if (cmd.advance) begin
      out_cell_index <= index_full[gdw_pkg::INDEX_W-1:0];
      out_exit_t     <= exit_t;
      out_last       <= done;
    end
  end

endmodule

// ===== hw/rtl/grid_dda_cell_walker_top.sv =====
// Grid DDA cell walker: walks one ray through a uniform 3D grid cell by cell.
// Input channel (in_*): one ray setup per item, holding the start cell, the near
// slab time, the per-cell time step and the direction class of each axis.
// Output channel (out_*): one item per visited cell with the linear cell index
// and the exit time of that cell; out_tlast marks the step that leaves the grid.
// Configuration port (cfg_*): grid divisions per axis at byte addresses 0, 4, 8,
// written by the user only while no ray is in flight; not enforced by the block.
// Flow: a ray is accepted into the walk registers, then one cell item is registered
// per cycle while the receiver takes them. A ray visits at most div_x+div_y+div_z-2
// cells; the walk loop, one step of the shared compare and accumulate unit per cell,
// sets that bound.
// A new ray is accepted in the cycle after the last cell item is registered,
// while that item may still wait in the output register.
// When out_tready is low the walk holds with the pending item in the output
// register. Reset idles the walker, drops any pending item and sets all three
// divisions to 16.
module grid_dda_cell_walker_top #(
  parameter int MAX_DIVS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata, from bit 0 up: start_x, start_y, start_z, entry_t_x, entry_t_y,
  // entry_t_z, step_t_x, step_t_y, step_t_z, dir_x, dir_y, dir_z, zero pad.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [gdw_pkg::IN_DATA_W-1:0]      in_tdata,
  // out_tdata, from bit 0 up: cell_index, exit_t, zero pad.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [gdw_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [3:0]                         cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int DW      = gdw_pkg::DIV_W;
  localparam int CAP_INT = (MAX_DIVS > 31) ? 31 : MAX_DIVS;
  localparam logic [DW-1:0] DIV_CAP = DW'(CAP_INT);

  logic [DW-1:0] div_r [3];
  logic [DW-1:0] div_eff [3];

  logic        [gdw_pkg::START_W-1:0] start   [3];
  logic signed [gdw_pkg::TIME_W-1:0]  entry_t [3];
  logic        [gdw_pkg::STEP_W-1:0]  step_t  [3];
  logic        [gdw_pkg::DIR_W-1:0]   dir     [3];

  logic        [gdw_pkg::INDEX_W-1:0] cell_index;
  logic signed [gdw_pkg::TIME_W-1:0]  exit_t;

  gdw_pkg::gdw_cmd_t    cmd;
  gdw_pkg::gdw_status_t status;

  // Configuration registers; a write completes in the access phase.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        div_r[i] <= 5'd16;
      end
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (cfg_paddr[3:2])
        gdw_pkg::REG_DIV_X: div_r[0] <= cfg_pwdata[DW-1:0];
        gdw_pkg::REG_DIV_Y: div_r[1] <= cfg_pwdata[DW-1:0];
        gdw_pkg::REG_DIV_Z: div_r[2] <= cfg_pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_paddr[3:2])
      gdw_pkg::REG_DIV_X: cfg_prdata = {27'd0, div_r[0]};
      gdw_pkg::REG_DIV_Y: cfg_prdata = {27'd0, div_r[1]};
      gdw_pkg::REG_DIV_Z: cfg_prdata = {27'd0, div_r[2]};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  // Effective divisions: zero counts as one, large values clamp to the grid limit.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (div_r[i] == '0) begin
        div_eff[i] = 5'd1;
      end else if (div_r[i] > DIV_CAP) begin
        div_eff[i] = DIV_CAP;
      end else begin
        div_eff[i] = div_r[i];
      end
    end
  end

  // Unpack the ray setup item.
  assign start[0]   = in_tdata[3:0];
  assign start[1]   = in_tdata[7:4];
  assign start[2]   = in_tdata[11:8];
  assign entry_t[0] = in_tdata[43:12];
  assign entry_t[1] = in_tdata[75:44];
  assign entry_t[2] = in_tdata[107:76];
  assign step_t[0]  = in_tdata[138:108];
  assign step_t[1]  = in_tdata[169:139];
  assign step_t[2]  = in_tdata[200:170];
  assign dir[0]     = in_tdata[202:201];
  assign dir[1]     = in_tdata[204:203];
  assign dir[2]     = in_tdata[206:205];

  gdw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  gdw_datapath u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .status         (status),
    .div_eff        (div_eff),
    .start          (start),
    .entry_t        (entry_t),
    .step_t         (step_t),
    .dir            (dir),
    .out_cell_index (cell_index),
    .out_exit_t     (exit_t),
    .out_last       (out_tlast)
  );

  // Pack the cell item.
  assign out_tdata = {4'd0, exit_t, cell_index};

endmodule

// ===== tb/grid_dda_cell_walker_checker.sv =====
module grid_dda_cell_walker_checker #(
  parameter int MAX_DIVS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [gdw_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [gdw_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tlast,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [3:0]                     cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  input  logic [31:0]                    cfg_prdata,
  input  logic                           cfg_pready,
  output int                             failures,
  output int                             cells_due,
  output int                             rays_seen,
  output int                             cells_checked
);

  timeunit 1ns;
  timeprecision 1ps;

  // Bit offsets of the field groups inside an input item.
  localparam int OFS_ENTRY = 3 * gdw_pkg::START_W;
  localparam int OFS_STEP  = OFS_ENTRY + 3 * gdw_pkg::TIME_W;
  localparam int OFS_DIR   = OFS_STEP + 3 * gdw_pkg::STEP_W;
  localparam int PAD_LO    = gdw_pkg::INDEX_W + gdw_pkg::TIME_W;

  typedef struct {
    logic [gdw_pkg::INDEX_W-1:0] cell_index;
    logic [gdw_pkg::TIME_W-1:0]  exit_t;
    logic                        last;
  } cell_visit_t;

  // Cell items predicted but not yet seen on the result channel, oldest first.
  cell_visit_t visits_due[$];

  // Shadow of the division registers, indexed by register index.
  logic [gdw_pkg::DIV_W-1:0] div_reg [3];

  // A zero division acts as one cell and anything above the maximum as the maximum.
  function automatic int clip_div(input logic [gdw_pkg::DIV_W-1:0] d);
    if (d == '0) return 1;
    if (int'(d) > MAX_DIVS) return MAX_DIVS;
    return int'(d);
  endfunction

  // Saturate to the signed Q16.16 range.
  function automatic longint clamp_q(input longint v);
    if (v > longint'(gdw_pkg::Q_MAX)) return longint'(gdw_pkg::Q_MAX);
    if (v < longint'(gdw_pkg::Q_MIN)) return longint'(gdw_pkg::Q_MIN);
    return v;
  endfunction

  // Walk one ray through the grid and queue every cell it visits.
  function automatic void walk_ray(input logic [gdw_pkg::IN_DATA_W-1:0] ray);
    int dv [3];
    int pos [3];
    int stride [3];
    int stop_at [3];
    longint cross_at [3];
    longint dt [3];
    longint t0;
    logic [gdw_pkg::DIR_W-1:0] dir;
    int s;
    int a;
    int n;
    int idx;
    logic done;
    cell_visit_t v;

    for (int i = 0; i < 3; i++) begin
      dv[i] = clip_div(div_reg[i]);
      s = int'(ray[gdw_pkg::START_W*i +: gdw_pkg::START_W]);
      if (s > dv[i] - 1) s = dv[i] - 1;
      pos[i] = s;
      t0 = longint'($signed(ray[OFS_ENTRY + gdw_pkg::TIME_W*i +: gdw_pkg::TIME_W]));
      dt[i] = longint'(ray[OFS_STEP + gdw_pkg::STEP_W*i +: gdw_pkg::STEP_W]);
      dir = ray[OFS_DIR + gdw_pkg::DIR_W*i +: gdw_pkg::DIR_W];
      // Negative and parallel axes both count down toward -1.
      stride[i] = -1;
      stop_at[i] = -1;
      if (dir == gdw_pkg::DIR_POS) begin
        cross_at[i] = clamp_q(t0 + longint'(s + 1) * dt[i]);
        stride[i] = 1;
        stop_at[i] = dv[i];
      end else if (dir == gdw_pkg::DIR_NEG) begin
        cross_at[i] = clamp_q(t0 + longint'(dv[i] - s) * dt[i]);
      end else begin
        cross_at[i] = longint'(gdw_pkg::Q_MAX);
      end
    end

    // Step the axis with the strictly smallest crossing; ties favor z over y over x.
    n = 0;
    done = 1'b0;
    while (!done && n < 3 * MAX_DIVS - 2) begin
      if (cross_at[0] < cross_at[1] && cross_at[0] < cross_at[2]) a = 0;
      else if (cross_at[1] < cross_at[2]) a = 1;
      else a = 2;
      idx = pos[0] + dv[0] * pos[1] + dv[0] * dv[1] * pos[2];
      v.cell_index = idx[gdw_pkg::INDEX_W-1:0];
      v.exit_t = cross_at[a][gdw_pkg::TIME_W-1:0];
      cross_at[a] = clamp_q(cross_at[a] + dt[a]);
      done = (pos[a] + stride[a] == stop_at[a]);
      v.last = done;
      visits_due = {visits_due, v};
      n++;
      if (!done) pos[a] = pos[a] + stride[a];
    end
  endfunction

  always @(posedge clk) begin
    cell_visit_t due;
    logic [31:0] reg_value;

    if (!rst_n) begin
      visits_due.delete();
      for (int i = 0; i < 3; i++) div_reg[i] = 5'd16;
    end else begin
      // Compare each cell item leaving the block with the oldest prediction.
      if (out_tvalid && out_tready) begin
        if (visits_due.size() == 0) begin
          $error("unexpected cell item: cell_index %0d, exit_t %0d",
                 out_tdata[gdw_pkg::INDEX_W-1:0],
                 $signed(out_tdata[gdw_pkg::INDEX_W +: gdw_pkg::TIME_W]));
          failures++;
        end else begin
          due = visits_due.pop_front();
          cells_checked++;
          if (out_tdata[gdw_pkg::INDEX_W-1:0] !== due.cell_index) begin
            $error("cell_index: expected %0d, actual %0d", due.cell_index,
                   out_tdata[gdw_pkg::INDEX_W-1:0]);
            failures++;
          end
          if (out_tdata[gdw_pkg::INDEX_W +: gdw_pkg::TIME_W] !== due.exit_t) begin
            $error("exit_t: expected %0d, actual %0d", $signed(due.exit_t),
                   $signed(out_tdata[gdw_pkg::INDEX_W +: gdw_pkg::TIME_W]));
            failures++;
          end
          if (out_tlast !== due.last) begin
            $error("last: expected %0b, actual %0b", due.last, out_tlast);
            failures++;
          end
          if (out_tdata[gdw_pkg::OUT_DATA_W-1:PAD_LO] !== '0) begin
            $error("pad: expected 0, actual %0h", out_tdata[gdw_pkg::OUT_DATA_W-1:PAD_LO]);
            failures++;
          end
        end
      end

      // Each accepted ray expands into its list of visited cells.
      if (in_tvalid && in_tready) begin
        walk_ray(in_tdata);
        rays_seen++;
      end

      // Track register writes and check read data against the shadow copy.
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr[3:2] <= gdw_pkg::REG_DIV_Z) begin
        if (cfg_pwrite) begin
          div_reg[cfg_paddr[3:2]] = cfg_pwdata[gdw_pkg::DIV_W-1:0];
        end else begin
          reg_value = {{(32-gdw_pkg::DIV_W){1'b0}}, div_reg[cfg_paddr[3:2]]};
          if (cfg_prdata !== reg_value) begin
            $error("prdata: expected %0d, actual %0d", reg_value, cfg_prdata);
            failures++;
          end
        end
      end
    end
    cells_due = visits_due.size();
  end

endmodule

// ===== tb/grid_dda_cell_walker_top_test.sv =====
module grid_dda_cell_walker_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIVS       = 16;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int NUM_PHASES     = 8;
  localparam int RAYS_PER_PHASE = 30;

  // Field types of one ray setup.
  typedef logic [gdw_pkg::START_W-1:0] start_val_t;
  typedef logic [gdw_pkg::TIME_W-1:0]  q16_t;
  typedef logic [gdw_pkg::STEP_W-1:0]  step_val_t;
  typedef logic [gdw_pkg::DIR_W-1:0]   dir_val_t;
  typedef logic [gdw_pkg::DIV_W-1:0]   div_val_t;

  // The spare direction code, which the block treats as parallel.
  localparam dir_val_t DIR_SPARE = 2'd3;

  // One unit in Q16.16.
  localparam q16_t      T_ONE   = 32'h0001_0000;
  localparam step_val_t S_ONE   = 31'h0001_0000;
  localparam step_val_t S_TWO   = 31'h0002_0000;
  localparam step_val_t S_THREE = 31'h0003_0000;
  localparam step_val_t S_MAX   = 31'h7FFF_FFFF;

  // Ray setup as it travels on in_tdata, last field first.
  typedef struct packed {
    logic       pad;
    dir_val_t   dir_z;
    dir_val_t   dir_y;
    dir_val_t   dir_x;
    step_val_t  step_z;
    step_val_t  step_y;
    step_val_t  step_x;
    q16_t       entry_z;
    q16_t       entry_y;
    q16_t       entry_x;
    start_val_t start_z;
    start_val_t start_y;
    start_val_t start_x;
  } ray_t;

  logic                           clk;
  logic                           rst_n       = 1'b0;
  logic                           in_tvalid   = 1'b0;
  logic                           in_tready;
  // in_tdata, from bit 0 up: start_x, start_y, start_z, entry_t_x, entry_t_y,
  // entry_t_z, step_t_x, step_t_y, step_t_z, dir_x, dir_y, dir_z, zero pad.
  logic [gdw_pkg::IN_DATA_W-1:0]  in_tdata    = '0;
  logic                           out_tvalid;
  logic                           out_tready  = 1'b1;
  // out_tdata, from bit 0 up: cell_index, exit_t, zero pad.
  logic [gdw_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tlast;
  logic                           cfg_psel    = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite  = 1'b0;
  logic [3:0]                     cfg_paddr   = '0;
  logic [31:0]                    cfg_pwdata  = '0;
  logic [31:0]                    cfg_prdata;
  logic                           cfg_pready;

  int failures;
  int cells_due;
  int rays_seen;
  int cells_checked;
  int idle_pct;
  int ready_hold;
  int cycle_count;
  int grid_settings;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  grid_dda_cell_walker_top #(
    .MAX_DIVS(MAX_DIVS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  grid_dda_cell_walker_checker #(
    .MAX_DIVS(MAX_DIVS)
  ) i_walk_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready),
    .failures      (failures),
    .cells_due     (cells_due),
    .rays_seen     (rays_seen),
    .cells_checked (cells_checked)
  );

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d cell items outstanding.",
               cycle_count, cells_due);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The receiver stalls in random bursts.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      out_tready <= 1'b0;
    end else if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      ready_hold = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic ray_t ray_of(
    input start_val_t sx, sy, sz,
    input q16_t       tx, ty, tz,
    input step_val_t  ux, uy, uz,
    input dir_val_t   dx, dy, dz
  );
    ray_t r;
    r = '{pad: 1'b0, dir_z: dz, dir_y: dy, dir_x: dx,
          step_z: uz, step_y: uy, step_x: ux,
          entry_z: tz, entry_y: ty, entry_x: tx,
          start_z: sz, start_y: sy, start_x: sx};
    return r;
  endfunction

  // Mostly ordinary rays near time zero, some fully random and some near saturation.
  function automatic ray_t random_ray();
    start_val_t s [3];
    q16_t       t [3];
    step_val_t  u [3];
    dir_val_t   d [3];
    int flavor;

    flavor = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      s[i] = start_val_t'($urandom_range(0, 15));
      d[i] = dir_val_t'(($urandom_range(0, 7) == 0) ? $urandom_range(2, 3)
                                                    : $urandom_range(0, 1));
      if (flavor < 7) begin
        t[i] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        u[i] = ($urandom_range(0, 15) == 0) ? '0 :
               step_val_t'($urandom_range(32'h0000_1000, 32'h0004_0000));
      end else if (flavor < 9) begin
        t[i] = $urandom();
        u[i] = step_val_t'($urandom_range(0, 32'h7FFF_FFFF));
      end else begin
        t[i] = $urandom_range(0, 1)
               ? gdw_pkg::Q_MAX - $urandom_range(0, 32'h0010_0000)
               : gdw_pkg::Q_MIN + $urandom_range(0, 32'h0010_0000);
        u[i] = step_val_t'($urandom_range(32'h0100_0000, 32'h7FFF_FFFF));
      end
    end
    return ray_of(s[0], s[1], s[2], t[0], t[1], t[2], u[0], u[1], u[2], d[0], d[1], d[2]);
  endfunction

  // Offer one ray, sometimes after a short gap, and hold it until it is taken.
  task automatic send_ray(input ray_t r);
    if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tdata  <= r;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // One register transfer: a setup phase, then an access phase until pready.
  task automatic cfg_access(input logic wr, input logic [1:0] sel, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Program all three divisions and read them back.
  task automatic set_grid(input div_val_t nx, ny, nz);
    cfg_access(1'b1, gdw_pkg::REG_DIV_X, 32'(nx));
    cfg_access(1'b1, gdw_pkg::REG_DIV_Y, 32'(ny));
    cfg_access(1'b1, gdw_pkg::REG_DIV_Z, 32'(nz));
    cfg_access(1'b0, gdw_pkg::REG_DIV_X, '0);
    cfg_access(1'b0, gdw_pkg::REG_DIV_Y, '0);
    cfg_access(1'b0, gdw_pkg::REG_DIV_Z, '0);
    grid_settings++;
  endtask

  // Let every predicted cell item come out, then let the walker sit idle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (cells_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    div_val_t nd [3];

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rays on the reset grid of 16 cells per axis.
    idle_pct = 25;
    grid_settings = 1;
    send_ray(ray_of(0, 0, 0, '0, '0, '0, S_ONE, S_ONE, S_ONE,
                    gdw_pkg::DIR_POS, gdw_pkg::DIR_POS, gdw_pkg::DIR_POS));
    send_ray(ray_of(15, 15, 15, '0, '0, '0, S_ONE, S_TWO, S_THREE,
                    gdw_pkg::DIR_NEG, gdw_pkg::DIR_NEG, gdw_pkg::DIR_NEG));
    send_ray(ray_of(7, 3, 9, T_ONE, '0, -T_ONE, S_ONE, S_ONE, S_ONE,
                    gdw_pkg::DIR_PAR, gdw_pkg::DIR_PAR, gdw_pkg::DIR_PAR));
    send_ray(ray_of(2, 12, 5, '0, '0, '0, S_ONE, S_ONE, S_ONE,
                    DIR_SPARE, DIR_SPARE, DIR_SPARE));
    send_ray(ray_of(15, 0, 15, '0, '0, '0, S_ONE, S_ONE, S_ONE,
                    gdw_pkg::DIR_POS, gdw_pkg::DIR_POS, gdw_pkg::DIR_NEG));
    send_ray(ray_of(4, 8, 1, gdw_pkg::Q_MAX, gdw_pkg::Q_MAX, gdw_pkg::Q_MAX,
                    S_MAX, S_MAX, S_MAX,
                    gdw_pkg::DIR_POS, gdw_pkg::DIR_NEG, gdw_pkg::DIR_POS));
    send_ray(ray_of(3, 6, 10, gdw_pkg::Q_MIN, gdw_pkg::Q_MIN, gdw_pkg::Q_MIN, '0, '0, '0,
                    gdw_pkg::DIR_POS, gdw_pkg::DIR_POS, gdw_pkg::DIR_POS));
    send_ray(ray_of(0, 15, 8, gdw_pkg::Q_MIN, gdw_pkg::Q_MIN, gdw_pkg::Q_MIN,
                    S_MAX, S_MAX, S_MAX,
                    gdw_pkg::DIR_NEG, gdw_pkg::DIR_POS, gdw_pkg::DIR_NEG));
    send_ray(ray_of(9, 9, 9, '0, T_ONE, 2 * T_ONE, S_ONE, S_ONE >> 1, S_ONE,
                    gdw_pkg::DIR_PAR, gdw_pkg::DIR_POS, gdw_pkg::DIR_NEG));
    send_ray(ray_of(5, 10, 14, -T_ONE, -T_ONE, -T_ONE, '0, S_ONE, '0,
                    gdw_pkg::DIR_NEG, gdw_pkg::DIR_NEG, gdw_pkg::DIR_NEG));
    send_ray(ray_of(0, 15, 0, '0, '0, '0, S_MAX, S_MAX, S_MAX,
                    gdw_pkg::DIR_POS, gdw_pkg::DIR_NEG, gdw_pkg::DIR_POS));
    send_ray(ray_of(1, 2, 3, 32'h7FFF_0000, 32'h7FFE_0000, 32'h7FFD_0000, S_ONE, S_ONE, S_ONE,
                    gdw_pkg::DIR_POS, gdw_pkg::DIR_POS, gdw_pkg::DIR_POS));
    send_ray(ray_of(11, 4, 6, 32'h8000_0001, '0, 32'h7FFF_FFFF, S_ONE, S_THREE, S_ONE,
                    gdw_pkg::DIR_POS, DIR_SPARE, gdw_pkg::DIR_NEG));
    send_ray(ray_of(15, 15, 15, '1, '1, '1, S_MAX, S_ONE, S_MAX,
                    gdw_pkg::DIR_NEG, gdw_pkg::DIR_PAR, gdw_pkg::DIR_POS));
    drain();

    // Random rays over a sequence of grid shapes, extremes first.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_grid(1, 1, 1);
        1: set_grid(16, 16, 16);
        2: set_grid(0, 31, 7);
        3: set_grid(2, 16, 3);
        default: begin
          for (int k = 0; k < 3; k++) begin
            nd[k] = div_val_t'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                           : $urandom_range(1, 16));
          end
          set_grid(nd[0], nd[1], nd[2]);
        end
      endcase
      // Some phases run without idling, the last one always.
      if (p == NUM_PHASES - 1 || p % 3 == 2) idle_pct = 0;
      else if (p % 3 == 0) idle_pct = 20;
      else idle_pct = 40;
      repeat (RAYS_PER_PHASE) send_ray(random_ray());
      drain();
    end

    repeat (8) @(negedge clk);
    $display("Walked %0d rays over %0d grid shapes and compared %0d cell items.",
             rays_seen, grid_settings, cells_checked);
    $display("Shapes ranged from single cells to 16 per axis, with zero and oversize divisions.");
    if (failures == 0 && cells_due == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/gdw_pkg.sv
hw/rtl/gdw_ctrl.sv
hw/rtl/gdw_datapath.sv
hw/rtl/grid_dda_cell_walker_top.sv
tb/grid_dda_cell_walker_checker.sv
tb/grid_dda_cell_walker_top_test.sv
